// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion lbl failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion lbl failed");

`endif

// ===== hw/rtl/bdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdhr_pkg
// types and constants of the button debouncer with hold and auto-repeat
// ----------------------------------------------------------------------------
package bdhr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int EVENT_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL  = 2'd0,
        CFG_FIRST_HOLD_MS = 2'd1,
        CFG_REPEAT_MS     = 2'd2,
        CFG_DEBOUNCE_MS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        active_level;
        logic [15:0] first_hold_ms;
        logic [15:0] repeat_ms;
        logic [7:0]  debounce_ms;
    } t_cfg;

    localparam logic        ACTIVE_LEVEL_RST  = 1'b1;
    localparam logic [15:0] FIRST_HOLD_MS_RST = 16'd800;
    localparam logic [15:0] REPEAT_MS_RST     = 16'd200;
    localparam logic [7:0]  DEBOUNCE_MS_RST   = 8'd20;

    typedef enum logic [EVENT_W-1:0] {
        EV_UP               = 4'd0,
        EV_DOWN_SHORT       = 4'd1,
        EV_DOWN_LONG_FIRST  = 4'd2,
        EV_DOWN_LONG_REPEAT = 4'd3,
        EV_PRESS            = 4'd4,
        EV_REL_SHORT        = 4'd5,
        EV_LONG_FIRST       = 4'd6,
        EV_REL_LONG_FIRST   = 4'd7,
        EV_LONG_REPEAT      = 4'd8,
        EV_REL_LONG_REPEAT  = 4'd9
    } t_event;

    typedef enum logic [5:0] {
        M_UP               = 6'b000001,
        M_DOWN_SHORT       = 6'b000010,
        M_DOWN_LONG_FIRST  = 6'b000100,
        M_DOWN_LONG_REPEAT = 6'b001000,
        M_DEB_UP           = 6'b010000,
        M_DEB_DOWN         = 6'b100000
    } t_mode;

    // which interval a new deadline is built from
    typedef enum logic [1:0] {
        DL_DEBOUNCE   = 2'd0,
        DL_FIRST_HOLD = 2'd1,
        DL_REPEAT     = 2'd2
    } t_dl_sel;

endpackage

// ===== hw/rtl/button_debounce_hold_repeat_top.sv =====
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat_top
// an accepted poll is registered at the input, then its event item in the output register
// throughput: one poll per cycle while the output is not stalled, set by the mode/deadline update
// reset (synchronous, active low): registers to defaults, mode up, deadline 0
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat_top
    import bdhr_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_pin_level,
    input  logic [31:0]           i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [EVENT_W-1:0]    o_event_code
);

    t_cfg                  w_cfg;
    logic [TIME_WIDTH-1:0] w_now_fit;
    logic                  r_in_valid;
    logic                  r_pin;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_out_valid;
    logic [EVENT_W-1:0]    r_out_code;
    logic                  w_out_free;
    logic                  w_step;
    t_event                w_event;

    // time stamp brought to TIME_WIDTH bits
    generate
        if (TIME_WIDTH > 32) begin : g_wide
            assign w_now_fit = {{(TIME_WIDTH-32){1'b0}}, i_now_ms};
        end else if (TIME_WIDTH == 32) begin : g_same
            assign w_now_fit = i_now_ms;
        end else begin : g_narrow
            assign w_now_fit = i_now_ms[TIME_WIDTH-1:0];
        end
    endgenerate

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pin <= i_pin_level;
            r_now <= w_now_fit;
        end
    end

    bdhr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bdhr_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_pin_level (r_pin),
        .i_now       (r_now),
        .i_cfg       (w_cfg),
        .o_event     (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_code <= w_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_out_code;

endmodule

// ===== hw/rtl/bdhr_cfg.sv =====
// ----------------------------------------------------------------------------
// bdhr_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module bdhr_cfg
    import bdhr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level  <= ACTIVE_LEVEL_RST;
            r_cfg.first_hold_ms <= FIRST_HOLD_MS_RST;
            r_cfg.repeat_ms     <= REPEAT_MS_RST;
            r_cfg.debounce_ms   <= DEBOUNCE_MS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE_LEVEL:  r_cfg.active_level  <= i_cfg_data[0];
                CFG_FIRST_HOLD_MS: r_cfg.first_hold_ms <= i_cfg_data[15:0];
                CFG_REPEAT_MS:     r_cfg.repeat_ms     <= i_cfg_data[15:0];
                CFG_DEBOUNCE_MS:   r_cfg.debounce_ms   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/bdhr_core.sv =====
// ----------------------------------------------------------------------------
// bdhr_core
// mode and deadline state with the per-poll event decision
// ----------------------------------------------------------------------------
module bdhr_core
    import bdhr_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_pin_level,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  t_cfg                  i_cfg,
    output t_event                o_event
);

    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [TIME_WIDTH-1:0] r_deadline;
    logic [TIME_WIDTH-1:0] n_deadline;

    logic                  w_pressed;
    logic                  w_due;
    logic                  w_load;
    t_dl_sel               w_sel;
    logic [TIME_WIDTH-1:0] w_delta;
    t_event                w_event;

    assign w_pressed = (i_pin_level == i_cfg.active_level);
    assign w_due     = (i_now >= r_deadline);

    always_comb begin
        n_mode  = r_mode;
        w_load  = 1'b0;
        w_sel   = DL_DEBOUNCE;
        w_event = EV_UP;
        unique case (r_mode)
            M_DOWN_SHORT: begin
                if (!w_pressed) begin
                    w_load = 1'b1; n_mode = M_DEB_UP; w_event = EV_REL_SHORT;
                end else if (w_due) begin
                    w_load = 1'b1; w_sel = DL_REPEAT;
                    n_mode = M_DOWN_LONG_FIRST; w_event = EV_LONG_FIRST;
                end else begin
                    w_event = EV_DOWN_SHORT;
                end
            end
            M_DOWN_LONG_FIRST: begin
                if (!w_pressed) begin
                    w_load = 1'b1; n_mode = M_DEB_UP; w_event = EV_REL_LONG_FIRST;
                end else if (w_due) begin
                    w_load = 1'b1; w_sel = DL_REPEAT;
                    n_mode = M_DOWN_LONG_REPEAT; w_event = EV_LONG_REPEAT;
                end else begin
                    w_event = EV_DOWN_LONG_FIRST;
                end
            end
            M_DOWN_LONG_REPEAT: begin
                if (!w_pressed) begin
                    w_load = 1'b1; n_mode = M_DEB_UP; w_event = EV_REL_LONG_REPEAT;
                end else if (w_due) begin
                    w_load = 1'b1; w_sel = DL_REPEAT; w_event = EV_LONG_REPEAT;
                end else begin
                    w_event = EV_DOWN_LONG_REPEAT;
                end
            end
            M_DEB_UP: begin
                if (w_due) n_mode = M_UP;
                w_event = EV_UP;
            end
            M_DEB_DOWN: begin
                if (w_due) begin
                    w_load = 1'b1; w_sel = DL_FIRST_HOLD; n_mode = M_DOWN_SHORT;
                end
                w_event = EV_DOWN_SHORT;
            end
            default: begin
                // idle, also catches any stray code
                if (w_pressed) begin
                    w_load = 1'b1; n_mode = M_DEB_DOWN; w_event = EV_PRESS;
                end else begin
                    n_mode = M_UP; w_event = EV_UP;
                end
            end
        endcase
    end

    always_comb begin
        case (w_sel)
            DL_FIRST_HOLD: w_delta = TIME_WIDTH'(i_cfg.first_hold_ms);
            DL_REPEAT:     w_delta = TIME_WIDTH'(i_cfg.repeat_ms);
            default:       w_delta = TIME_WIDTH'(i_cfg.debounce_ms);
        endcase
    end

    // wraps modulo 2^TIME_WIDTH
    assign n_deadline = w_load ? (i_now + w_delta) : r_deadline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_UP;
            r_deadline <= '0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_deadline <= n_deadline;
        end
    end

    assign o_event = w_event;

endmodule

// ===== hw/rtl/bdhr_checker.sv =====
// ----------------------------------------------------------------------------
// bdhr_checker
// port-level checks of the debouncer top, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdhr_checker
    import bdhr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [EVENT_W-1:0] o_event_code
);

    // event codes stay within the defined set
    `ASSERT_IMPL(a_code_range, i_clk, i_rst_n, o_out_valid, o_event_code <= EV_REL_LONG_REPEAT)

    // input only backs up when a finished item is held on the output
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // an accepted poll passes the input register and shows up on the output when the output moves
    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall) ##1 !i_out_stall, o_out_valid)

    // a held result does not change
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_event_code))

endmodule

bind button_debounce_hold_repeat_top bdhr_checker u_bdhr_checker (.*);

// ===== verif/tb_button_debounce_hold_repeat_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_debounce_hold_repeat_top
// Self-checking bench for the button debouncer with hold and auto-repeat.
// Polls are driven through the valid/stall input channel. Each accepted poll
// advances a behavioral copy of the mode and deadline, which queues the
// event code it should produce. Event items are checked in order against
// that queue. The run goes through register settings that include both
// extremes, and through phases with no idling, heavy sender gaps, heavy
// receiver stalls and a mix of both.
// ----------------------------------------------------------------------------
import bdhr_pkg::*;

class press_event_tracker;
    t_cfg         cfg;
    t_mode        mode;
    logic [31:0]  deadline;
    t_event       expected_events[$];
    int unsigned  polls;
    int unsigned  events_checked;
    int unsigned  errors;
    int unsigned  seen[10];

    function new();
        cfg.active_level  = ACTIVE_LEVEL_RST;
        cfg.first_hold_ms = FIRST_HOLD_MS_RST;
        cfg.repeat_ms     = REPEAT_MS_RST;
        cfg.debounce_ms   = DEBOUNCE_MS_RST;
        mode              = M_UP;
        deadline          = '0;
        polls             = 0;
        events_checked    = 0;
        errors            = 0;
        foreach (seen[k]) seen[k] = 0;
    endfunction

    // only the register's own width is kept
    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ACTIVE_LEVEL:  cfg.active_level  = data[0];
            CFG_FIRST_HOLD_MS: cfg.first_hold_ms = data[15:0];
            CFG_REPEAT_MS:     cfg.repeat_ms     = data[15:0];
            CFG_DEBOUNCE_MS:   cfg.debounce_ms   = data[7:0];
            default: ;
        endcase
    endfunction

    function void note_poll(logic pin, logic [31:0] now);
        logic   pressed;
        logic   due;
        t_event ev;
        pressed = (pin == cfg.active_level);
        due     = (now >= deadline);
        case (mode)
            // in every down mode a release is handled ahead of the deadline
            M_DOWN_SHORT: begin
                if (!pressed) begin
                    deadline = now + cfg.debounce_ms;
                    mode     = M_DEB_UP;
                    ev       = EV_REL_SHORT;
                end else if (due) begin
                    deadline = now + cfg.repeat_ms;
                    mode     = M_DOWN_LONG_FIRST;
                    ev       = EV_LONG_FIRST;
                end else begin
                    ev = EV_DOWN_SHORT;
                end
            end
            M_DOWN_LONG_FIRST: begin
                if (!pressed) begin
                    deadline = now + cfg.debounce_ms;
                    mode     = M_DEB_UP;
                    ev       = EV_REL_LONG_FIRST;
                end else if (due) begin
                    deadline = now + cfg.repeat_ms;
                    mode     = M_DOWN_LONG_REPEAT;
                    ev       = EV_LONG_REPEAT;
                end else begin
                    ev = EV_DOWN_LONG_FIRST;
                end
            end
            M_DOWN_LONG_REPEAT: begin
                if (!pressed) begin
                    deadline = now + cfg.debounce_ms;
                    mode     = M_DEB_UP;
                    ev       = EV_REL_LONG_REPEAT;
                end else if (due) begin
                    deadline = now + cfg.repeat_ms;
                    ev       = EV_LONG_REPEAT;
                end else begin
                    ev = EV_DOWN_LONG_REPEAT;
                end
            end
            M_DEB_UP: begin
                if (due) mode = M_UP;
                ev = EV_UP;
            end
            M_DEB_DOWN: begin
                if (due) begin
                    deadline = now + cfg.first_hold_ms;
                    mode     = M_DOWN_SHORT;
                end
                ev = EV_DOWN_SHORT;
            end
            default: begin
                if (pressed) begin
                    deadline = now + cfg.debounce_ms;
                    mode     = M_DEB_DOWN;
                    ev       = EV_PRESS;
                end else begin
                    mode = M_UP;
                    ev   = EV_UP;
                end
            end
        endcase
        expected_events.push_back(ev);
        polls++;
    endfunction

    function void check_event(logic [EVENT_W-1:0] code);
        t_event want;
        if (code < 10) seen[code]++;
        if (expected_events.size() == 0) begin
            $display("%0t: event_code %0d arrived with none expected", $time, code);
            errors++;
        end else begin
            want = expected_events.pop_front();
            events_checked++;
            if (code !== want) begin
                $display("%0t: event_code mismatch, expected %0d (%s) got %0d",
                         $time, want, want.name(), code);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_events.size();
    endfunction
endclass

module tb_button_debounce_hold_repeat_top;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_POLLS  = 125;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_pin_level;
    logic [31:0]           i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [EVENT_W-1:0]    o_event_code;

    press_event_tracker tracker;

    int unsigned cycle_count;
    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] clock_ms;
    logic        active_now;
    int unsigned step_max;
    int unsigned kinds_seen;

    button_debounce_hold_repeat_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pin_level  (i_pin_level),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_code (o_event_code)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // receiver side: stall rolled fresh every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_event(o_event_code);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("button_debounce_hold_repeat_top verification failed");
        $finish;
    end

    task automatic send_poll(input logic pin, input logic [31:0] now);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_pin_level = pin;
        i_now_ms    = now;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_poll(pin, now);
    endtask

    // advance the millisecond clock, often by a little so waits are not always over
    task automatic timed_poll(input logic pin);
        if ($urandom_range(0, 3) == 0) clock_ms += $urandom_range(0, 3);
        else                           clock_ms += $urandom_range(0, step_max);
        send_poll(pin, clock_ms);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int phase);
        logic        act;
        logic [15:0] hold;
        logic [15:0] rep;
        logic [7:0]  deb;
        int unsigned span;
        case (phase)
            0: begin act = 1'b1; hold = 16'd30;    rep = 16'd10;    deb = 8'd5;   end
            1: begin act = 1'b0; hold = 16'd0;     rep = 16'd0;     deb = 8'd0;   end
            2: begin act = 1'b1; hold = 16'hFFFF;  rep = 16'hFFFF;  deb = 8'hFF;  end
            3: begin act = 1'b0; hold = 16'd100;   rep = 16'd1;     deb = 8'd3;   end
            6: begin act = 1'b1; hold = 16'd1;     rep = 16'hFFFF;  deb = 8'hFF;  end
            default: begin
                act  = 1'($urandom_range(0, 1));
                hold = 16'($urandom_range(0, 65535));
                rep  = 16'($urandom_range(0, 400));
                deb  = 8'($urandom_range(0, 255));
            end
        endcase
        // upper data bits are junk for the narrow registers, or all ones at the top end
        if (phase == 2) begin
            write_reg(CFG_ACTIVE_LEVEL, 16'hFFFF);
            write_reg(CFG_DEBOUNCE_MS, 16'hFFFF);
        end else begin
            write_reg(CFG_ACTIVE_LEVEL, {15'($urandom()), act});
            write_reg(CFG_DEBOUNCE_MS, {8'($urandom()), deb});
        end
        write_reg(CFG_FIRST_HOLD_MS, hold);
        write_reg(CFG_REPEAT_MS, rep);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        active_now = act;
        span = hold;
        if (rep > span) span = rep;
        if (deb > span) span = deb;
        step_max = (span >> 2) + 2;
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
        endcase
    endtask

    // released polls, an optional bounce, a hold of random length, then a release
    task automatic press_and_release();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) timed_poll(~active_now);
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) timed_poll(1'($urandom_range(0, 1)));
        end
        n = $urandom_range(1, 20);
        repeat (n) timed_poll(active_now);
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) timed_poll(1'($urandom_range(0, 1)));
            else                           timed_poll(~active_now);
        end
    endtask

    initial begin
        int          phase;
        int unsigned phase_start;
        int          roll;
        int          n;
        tracker       = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ACTIVE_LEVEL;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pin_level   = 1'b0;
        i_now_ms      = '0;
        i_out_stall   = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        clock_ms      = '0;
        active_now    = ACTIVE_LEVEL_RST;
        step_max      = 8;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk with the reset settings: every event, wrap of the stamp,
        // and a release that comes after the deadline has already passed
        send_poll(1'b0, 32'd0);
        send_poll(1'b1, 32'd100);
        send_poll(1'b1, 32'd110);
        send_poll(1'b1, 32'd120);
        send_poll(1'b1, 32'd500);
        send_poll(1'b1, 32'd920);
        send_poll(1'b1, 32'd1000);
        send_poll(1'b1, 32'd1120);
        send_poll(1'b1, 32'd1200);
        send_poll(1'b1, 32'd1320);
        send_poll(1'b0, 32'd1330);
        send_poll(1'b1, 32'd1340);
        send_poll(1'b0, 32'd1350);
        send_poll(1'b1, 32'd2000);
        send_poll(1'b1, 32'd2020);
        send_poll(1'b0, 32'd2100);
        send_poll(1'b0, 32'd2120);
        send_poll(1'b1, 32'd3000);
        send_poll(1'b1, 32'd3020);
        send_poll(1'b1, 32'd3820);
        send_poll(1'b0, 32'd3830);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b1, 32'd5);
        send_poll(1'b0, 32'd900);
        drain();

        for (phase = 0; phase < PHASES; phase++) begin
            apply_setting(phase);
            phase_start = tracker.polls;
            while (tracker.polls - phase_start < PHASE_POLLS) begin
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    press_and_release();
                end else if (roll < 85) begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_poll(1'($urandom_range(0, 1)), $urandom());
                end else if (roll < 92) begin
                    // run the press across the wrap of the time stamp
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
                    press_and_release();
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) timed_poll(~active_now);
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        kinds_seen = 0;
        foreach (tracker.seen[k]) if (tracker.seen[k] != 0) kinds_seen++;
        $display("%0d polls over %0d register settings, %0d event items checked",
                 tracker.polls, PHASES + 1, tracker.events_checked);
        $display("%0d of 10 event kinds observed, %0d mismatches", kinds_seen,
                 tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("button_debounce_hold_repeat_top verification clean");
        end else begin
            $display("button_debounce_hold_repeat_top verification failed");
        end
        $finish;
    end

endmodule

// ===== button_debounce_hold_repeat_top.f =====
+incdir+hw/rtl
hw/rtl/bdhr_pkg.sv
hw/rtl/bdhr_cfg.sv
hw/rtl/bdhr_core.sv
hw/rtl/button_debounce_hold_repeat_top.sv
hw/rtl/bdhr_checker.sv
verif/tb_button_debounce_hold_repeat_top.sv
